FILE: hdl/cbad_pkg.sv
// Shared types and constants for the CPU bus address decoder.
`timescale 1ns / 1ps

package cbad_pkg;

    // Request codes
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_PAD   = 2'd2;

    // Target codes
    localparam logic [2:0] TGT_RAM      = 3'd0;
    localparam logic [2:0] TGT_PPU      = 3'd1;
    localparam logic [2:0] TGT_APU      = 3'd2;
    localparam logic [2:0] TGT_CART     = 3'd3;
    localparam logic [2:0] TGT_PAD      = 3'd4;
    localparam logic [2:0] TGT_IO       = 3'd5;
    localparam logic [2:0] TGT_UNMAPPED = 3'd6;
    localparam logic [2:0] TGT_DMA      = 3'd7;

    // Memory map boundaries
    localparam logic [15:0] ADDR_PPU_BASE  = 16'h2000;
    localparam logic [15:0] ADDR_PPU_LAST  = 16'h3FFF;
    localparam logic [15:0] ADDR_APU_LAST  = 16'h4013;
    localparam logic [15:0] ADDR_DMA       = 16'h4014;
    localparam logic [15:0] ADDR_APU_STAT  = 16'h4015;
    localparam logic [15:0] ADDR_PAD0      = 16'h4016;
    localparam logic [15:0] ADDR_PAD1      = 16'h4017;
    localparam logic [15:0] ADDR_UNMAPPED  = 16'h4018;
    localparam logic [15:0] ADDR_CART_BASE = 16'h6000;

    // Size of the mirrored RAM window below the PPU range
    localparam int RAM_WINDOW = 8192;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        pad_index;
        logic [7:0]  pad_buttons;
    } cbad_req_t;

    typedef struct packed {
        logic [2:0]  target;
        logic        is_write;
        logic [2:0]  ppu_register;
        logic [15:0] forward_address;
        logic [7:0]  forward_data;
        logic [7:0]  read_data;
    } cbad_rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } cbad_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;
        logic capture;
        logic commit;
    } cbad_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } cbad_stat_t;

endpackage

FILE: hdl/cpu_bus_address_decoder.sv
// A result is registered when its transaction commits, after the captured request and RAM read.
// A new transaction is taken only once the last one commits (registered RAM read, then commit);
// a held result only delays the commit of the following transaction.
// Reset: pads and DMA page clear at once; the work RAM is then swept to zero one address
// at a time, during which req_stall stays high.
`timescale 1ns / 1ps

module cpu_bus_address_decoder
    import cbad_pkg::*;
#(
    parameter int RAM_BYTES = 2048
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  cbad_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output cbad_rsp_t rsp
);

    cbad_cmd_t  cmd;
    cbad_stat_t stat;

    // Sequencer
    cbad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Decode and storage
    cbad_dp #(
        .RAM_BYTES (RAM_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

FILE: hdl/cbad_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cbad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/cbad_ctrl.sv
// Controller state machine: RAM clear after reset, capture and commit.
`timescale 1ns / 1ps

module cbad_ctrl
    import cbad_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  cbad_stat_t stat,
    output cbad_cmd_t  cmd
);

    cbad_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

FILE: hdl/cbad_dp.sv
// Datapath: address decode, work RAM, pad shift registers, DMA page, result register.
`timescale 1ns / 1ps

module cbad_dp
    import cbad_pkg::*;
#(
    parameter int RAM_BYTES = 2048
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cbad_req_t  req,
    input  cbad_cmd_t  cmd,
    output cbad_stat_t stat,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output cbad_rsp_t  rsp
);

    localparam int AW    = $clog2(RAM_BYTES);
    // quotient bits of a 13-bit window offset divided by RAM_BYTES
    localparam int QBITS = $clog2((RAM_WINDOW + RAM_BYTES - 1) / RAM_BYTES);
    localparam int WW    = $clog2(RAM_WINDOW) + 1;

    cbad_req_t        req_reg;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    idx_in;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [7:0]       pad_latch_reg [2];
    logic [7:0]       pad_latch_next [2];
    logic [7:0]       pad_shift_reg [2];
    logic [7:0]       pad_shift_next [2];
    logic [7:0]       dma_page_reg, dma_page_next;
    logic             rsp_valid_reg, rsp_valid_next;
    cbad_rsp_t        rsp_reg, rsp_next;
    logic [WW-1:0]    rem;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;
    logic             is_wr;
    logic             is_rd;
    logic             pad_sel;
    logic [15:0]      a;
    cbad_rsp_t        res;

    // Window offset modulo RAM_BYTES by compare and subtract
    always_comb
    begin
        rem = WW'(req.address[WW-2:0]);
        for (int j = QBITS - 1; j >= 0; j--)
        begin
            if (rem >= (WW'(RAM_BYTES) << j))
            begin
                rem = rem - (WW'(RAM_BYTES) << j);
            end
        end
        idx_in = rem[AW-1:0];
    end

    // Captured transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
            idx_reg <= idx_in;
        end
    end

    // Work RAM: read at capture, written when a write to the RAM range commits or during the clear sweep
    cbad_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.capture),
        .raddr (idx_in),
        .rdata (ram_rdata)
    );

    assign a     = req_reg.address;
    assign is_wr = (req_reg.req_type == REQ_WRITE);
    assign is_rd = (req_reg.req_type == REQ_READ);
    assign pad_sel = a[0];

    assign ram_we    = cmd.clear_en || (cmd.commit && is_wr && (a < ADDR_PPU_BASE));
    assign ram_waddr = cmd.clear_en ? clr_cnt_reg : idx_reg;
    assign ram_wdata = cmd.clear_en ? 8'h00 : req_reg.write_data;

    // Clear sweep counter
    assign clr_cnt_next    = cmd.clear_en ? clr_cnt_reg + AW'(1) : clr_cnt_reg;
    assign stat.clear_last = (clr_cnt_reg == AW'(RAM_BYTES - 1));
    assign stat.out_free   = !rsp_valid_reg || !rsp_stall;

    // Decode and local state updates
    always_comb
    begin
        res               = '0;
        res.target        = TGT_UNMAPPED;
        res.is_write      = is_wr;
        pad_latch_next[0] = pad_latch_reg[0];
        pad_latch_next[1] = pad_latch_reg[1];
        pad_shift_next[0] = pad_shift_reg[0];
        pad_shift_next[1] = pad_shift_reg[1];
        dma_page_next     = dma_page_reg;

        if (a < ADDR_PPU_BASE)
        begin
            res.target = TGT_RAM;
            if (!is_wr)
            begin
                res.read_data = ram_rdata;
            end
        end
        else if (a <= ADDR_PPU_LAST)
        begin
            res.target       = TGT_PPU;
            res.ppu_register = a[2:0];
            if (is_wr)
            begin
                res.forward_data = req_reg.write_data;
            end
        end
        else if (a >= ADDR_CART_BASE)
        begin
            res.target          = TGT_CART;
            res.forward_address = a;
            if (is_wr)
            begin
                res.forward_data = req_reg.write_data;
            end
        end
        else if (a >= ADDR_UNMAPPED)
        begin
            res.target = TGT_UNMAPPED;
        end
        else if (!is_wr)
        begin
            if (a == ADDR_APU_STAT)
            begin
                res.target          = TGT_APU;
                res.forward_address = a;
            end
            else if (a == ADDR_PAD0 || a == ADDR_PAD1)
            begin
                res.target             = TGT_PAD;
                res.read_data          = {7'b0, pad_shift_reg[pad_sel][7]};
                pad_shift_next[pad_sel] = {pad_shift_reg[pad_sel][6:0], 1'b0};
            end
            else
            begin
                res.target    = TGT_IO;
                res.read_data = (a == ADDR_DMA) ? dma_page_reg : 8'h00;
            end
        end
        else
        begin
            if (a == ADDR_PAD0)
            begin
                // strobe: both pads reload from their latches
                res.target        = TGT_PAD;
                pad_shift_next[0] = pad_latch_reg[0];
                pad_shift_next[1] = pad_latch_reg[1];
            end
            else if (a == ADDR_DMA)
            begin
                res.target       = TGT_DMA;
                dma_page_next    = req_reg.write_data;
                res.forward_data = req_reg.write_data;
            end
            else
            begin
                res.target          = TGT_APU;
                res.forward_address = a;
                res.forward_data    = req_reg.write_data;
            end
        end

        // Pad button update overrides the decode
        if (req_reg.req_type == REQ_PAD)
        begin
            pad_shift_next[0]                 = pad_shift_reg[0];
            pad_shift_next[1]                 = pad_shift_reg[1];
            dma_page_next                     = dma_page_reg;
            pad_latch_next[req_reg.pad_index] = req_reg.pad_buttons;
        end
        else if (!is_wr && !is_rd)
        begin
            pad_shift_next[0] = pad_shift_reg[0];
            pad_shift_next[1] = pad_shift_reg[1];
            dma_page_next     = dma_page_reg;
        end
    end

    // Result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (cmd.commit && (is_wr || is_rd))
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // Control and local state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg      <= '0;
            rsp_valid_reg    <= 1'b0;
            pad_latch_reg[0] <= 8'h00;
            pad_latch_reg[1] <= 8'h00;
            pad_shift_reg[0] <= 8'h00;
            pad_shift_reg[1] <= 8'h00;
            dma_page_reg     <= 8'h00;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.commit)
            begin
                pad_latch_reg[0] <= pad_latch_next[0];
                pad_latch_reg[1] <= pad_latch_next[1];
                pad_shift_reg[0] <= pad_shift_next[0];
                pad_shift_reg[1] <= pad_shift_next[1];
                dma_page_reg     <= dma_page_next;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
